FILE: hw/rtl/rapsg_pkg.sv
`timescale 1ns / 1ps

package rapsg_pkg;

    localparam int PRESSURE_W = 21;
    localparam int TIME_W     = 32;
    localparam int RATE_W     = 20;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // The rate term is (rate * dt) >> RATE_SHIFT.
    localparam int RATE_SHIFT = 20;
    localparam int PROD_W     = RATE_W + TIME_W;
    localparam int ALLOW_W    = PROD_W - RATE_SHIFT + 1;

    localparam logic [PRESSURE_W-1:0] MIN_PRESSURE_RST      = PRESSURE_W'(480000);
    localparam logic [PRESSURE_W-1:0] MAX_PRESSURE_RST      = PRESSURE_W'(1760000);
    localparam logic [PRESSURE_W-1:0] HARD_JUMP_RST         = PRESSURE_W'(32000);
    localparam logic [PRESSURE_W-1:0] BASE_JUMP_RST         = PRESSURE_W'(800);
    localparam logic [RATE_W-1:0]     MAX_RATE_RST          = RATE_W'(16000);
    localparam logic [PRESSURE_W-1:0] CONFIRM_TOLERANCE_RST = PRESSURE_W'(320);

    typedef enum logic [1:0] {
        VERDICT_ACCEPT    = 2'd0,
        VERDICT_INVALID   = 2'd1,
        VERDICT_HARD_JUMP = 2'd2,
        VERDICT_RATE      = 2'd3
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PRESSURE      = 3'd0,
        CFG_MAX_PRESSURE      = 3'd1,
        CFG_HARD_JUMP         = 3'd2,
        CFG_BASE_JUMP         = 3'd3,
        CFG_MAX_RATE          = 3'd4,
        CFG_CONFIRM_TOLERANCE = 3'd5,
        CFG_GUARD_ENABLE      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [PRESSURE_W-1:0] min_pressure;
        logic [PRESSURE_W-1:0] max_pressure;
        logic [PRESSURE_W-1:0] hard_jump;
        logic [PRESSURE_W-1:0] base_jump;
        logic [RATE_W-1:0]     max_rate;
        logic [PRESSURE_W-1:0] confirm_tolerance;
        logic                  guard_enable;
    } t_cfg;

    typedef struct packed {
        logic [PRESSURE_W-1:0] pressure;
        logic [TIME_W-1:0]     timestamp_us;
        logic                  conversion_ok;
        logic                  sample_ready;
    } t_sample;

    typedef struct packed {
        logic                  accepted;
        t_verdict              verdict;
        logic                  step_confirmed;
        logic [PRESSURE_W-1:0] reference_pressure;
        logic [COUNT_W-1:0]    reject_total;
        logic [COUNT_W-1:0]    confirm_total;
        logic [COUNT_W-1:0]    invalid_total;
    } t_result;

endpackage

FILE: hw/rtl/rapsg_cfg_regs.sv
`timescale 1ns / 1ps

module rapsg_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rapsg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rapsg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rapsg_pkg::t_cfg                  o_cfg
);
    import rapsg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_pressure      <= MIN_PRESSURE_RST;
            r_cfg.max_pressure      <= MAX_PRESSURE_RST;
            r_cfg.hard_jump         <= HARD_JUMP_RST;
            r_cfg.base_jump         <= BASE_JUMP_RST;
            r_cfg.max_rate          <= MAX_RATE_RST;
            r_cfg.confirm_tolerance <= CONFIRM_TOLERANCE_RST;
            r_cfg.guard_enable      <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_PRESSURE:      r_cfg.min_pressure      <= i_cfg_data[PRESSURE_W-1:0];
                CFG_MAX_PRESSURE:      r_cfg.max_pressure      <= i_cfg_data[PRESSURE_W-1:0];
                CFG_HARD_JUMP:         r_cfg.hard_jump         <= i_cfg_data[PRESSURE_W-1:0];
                CFG_BASE_JUMP:         r_cfg.base_jump         <= i_cfg_data[PRESSURE_W-1:0];
                CFG_MAX_RATE:          r_cfg.max_rate          <= i_cfg_data[RATE_W-1:0];
                CFG_CONFIRM_TOLERANCE: r_cfg.confirm_tolerance <= i_cfg_data[PRESSURE_W-1:0];
                CFG_GUARD_ENABLE:      r_cfg.guard_enable      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/rapsg_judge.sv
`timescale 1ns / 1ps

module rapsg_judge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  rapsg_pkg::t_sample i_sample,
    input  rapsg_pkg::t_cfg    i_cfg,
    output rapsg_pkg::t_result o_result
);
    import rapsg_pkg::*;

    function automatic logic [PRESSURE_W-1:0] abs_diff(
        input logic [PRESSURE_W-1:0] a,
        input logic [PRESSURE_W-1:0] b
    );
        logic [PRESSURE_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d;
    endfunction

    logic                  r_ref_valid,   n_ref_valid;
    logic [PRESSURE_W-1:0] r_ref_level,   n_ref_level;
    logic [TIME_W-1:0]     r_ref_time,    n_ref_time;
    logic                  r_cand_valid,  n_cand_valid;
    logic [PRESSURE_W-1:0] r_cand_level,  n_cand_level;
    logic [COUNT_W-1:0]    r_reject_cnt,  n_reject_cnt;
    logic [COUNT_W-1:0]    r_confirm_cnt, n_confirm_cnt;
    logic [COUNT_W-1:0]    r_invalid_cnt, n_invalid_cnt;

    logic                  in_range;
    logic [PRESSURE_W-1:0] delta;
    logic [PRESSURE_W-1:0] cand_diff;
    logic [TIME_W-1:0]     dt;
    logic [PROD_W-1:0]     prod;
    logic [ALLOW_W-1:0]    allow;
    logic                  rate_ok;
    logic                  cand_match;
    t_verdict              verdict;
    logic                  confirmed;

    assign in_range = i_sample.conversion_ok && i_sample.sample_ready &&
                      (i_sample.pressure >= i_cfg.min_pressure) &&
                      (i_sample.pressure <= i_cfg.max_pressure);

    assign delta     = abs_diff(i_sample.pressure, r_ref_level);
    assign cand_diff = abs_diff(i_sample.pressure, r_cand_level);
    assign dt        = i_sample.timestamp_us - r_ref_time;
    assign prod      = PROD_W'(i_cfg.max_rate) * PROD_W'(dt);
    assign allow     = {1'b0, prod[PROD_W-1:RATE_SHIFT]} + ALLOW_W'(i_cfg.base_jump);

    // The cap at hard_jump needs no logic of its own: this test is only used once the
    // step is already known to be within hard_jump.
    assign rate_ok    = ALLOW_W'(delta) <= allow;
    assign cand_match = r_cand_valid && (cand_diff <= i_cfg.confirm_tolerance);

    always_comb begin
        n_ref_valid   = r_ref_valid;
        n_ref_level   = r_ref_level;
        n_ref_time    = r_ref_time;
        n_cand_valid  = r_cand_valid;
        n_cand_level  = r_cand_level;
        n_reject_cnt  = r_reject_cnt;
        n_confirm_cnt = r_confirm_cnt;
        n_invalid_cnt = r_invalid_cnt;
        verdict       = VERDICT_ACCEPT;
        confirmed     = 1'b0;
        if (!in_range) begin
            verdict       = VERDICT_INVALID;
            n_invalid_cnt = r_invalid_cnt + COUNT_W'(1);
        end else if (!i_cfg.guard_enable || !r_ref_valid) begin
            n_ref_valid  = 1'b1;
            n_ref_level  = i_sample.pressure;
            n_ref_time   = i_sample.timestamp_us;
            n_cand_valid = 1'b0;
        end else if (delta > i_cfg.hard_jump) begin
            verdict      = VERDICT_HARD_JUMP;
            n_cand_valid = 1'b1;
            n_cand_level = i_sample.pressure;
            n_reject_cnt = r_reject_cnt + COUNT_W'(1);
        end else if (rate_ok) begin
            if (cand_match) begin
                confirmed     = 1'b1;
                n_confirm_cnt = r_confirm_cnt + COUNT_W'(1);
            end
            n_ref_valid  = 1'b1;
            n_ref_level  = i_sample.pressure;
            n_ref_time   = i_sample.timestamp_us;
            n_cand_valid = 1'b0;
        end else begin
            verdict      = VERDICT_RATE;
            n_cand_valid = 1'b1;
            n_cand_level = i_sample.pressure;
            n_reject_cnt = r_reject_cnt + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_valid   <= 1'b0;
            r_ref_level   <= '0;
            r_ref_time    <= '0;
            r_cand_valid  <= 1'b0;
            r_cand_level  <= '0;
            r_reject_cnt  <= '0;
            r_confirm_cnt <= '0;
            r_invalid_cnt <= '0;
        end else if (i_fire) begin
            r_ref_valid   <= n_ref_valid;
            r_ref_level   <= n_ref_level;
            r_ref_time    <= n_ref_time;
            r_cand_valid  <= n_cand_valid;
            r_cand_level  <= n_cand_level;
            r_reject_cnt  <= n_reject_cnt;
            r_confirm_cnt <= n_confirm_cnt;
            r_invalid_cnt <= n_invalid_cnt;
        end
    end

    always_comb begin
        o_result.accepted           = (verdict == VERDICT_ACCEPT);
        o_result.verdict            = verdict;
        o_result.step_confirmed     = confirmed;
        o_result.reference_pressure = n_ref_level;
        o_result.reject_total       = n_reject_cnt;
        o_result.confirm_total      = n_confirm_cnt;
        o_result.invalid_total      = n_invalid_cnt;
    end

    // Once a reference exists it is never dropped.
    a_ref_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_ref_valid))
        else $error("reference lost after being established");

    // A confirmed step always consumes the pending candidate.
    a_confirm_clears_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && confirmed) |=> (!r_cand_valid &&
            r_confirm_cnt == $past(r_confirm_cnt) + COUNT_W'(1)))
        else $error("confirmed step did not clear candidate or count");

    // An invalid sample touches only the invalid counter.
    a_invalid_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && verdict == VERDICT_INVALID) |=>
            (r_invalid_cnt == $past(r_invalid_cnt) + COUNT_W'(1) &&
             $stable(r_ref_level) && $stable(r_cand_valid) && $stable(r_reject_cnt)))
        else $error("invalid sample changed guard state");

    // A rejection by the step guard always leaves a pending candidate.
    a_reject_sets_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (verdict == VERDICT_HARD_JUMP || verdict == VERDICT_RATE)) |=>
            (r_cand_valid && r_reject_cnt == $past(r_reject_cnt) + COUNT_W'(1)))
        else $error("rejected sample not kept as candidate");

endmodule

FILE: hw/rtl/rate_aware_pressure_step_guard.sv
`timescale 1ns / 1ps

// Pressure step guard. Each input word carries one pressure sample (1/16 Pa), a wrapping
// microsecond timestamp and two sensor status flags; each produces exactly one result word
// with the verdict, the confirm flag, the reference after this sample and the three running
// counters. The block takes one word per clock while the consumer does not stall. A word
// accepted into the input register is judged there against the guard state, and its result
// moves into the output register once that register is empty or is being drained. The
// longest path is the 20 x 32 bit rate multiply followed by the allowance add and the step
// compare. The output register decouples the two sides: while a result waits for the
// consumer, one more word can still be taken into the input register. Configuration writes
// go to a plain register file and must only be made while the block is empty.
module rate_aware_pressure_step_guard (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_we,
    input  logic [rapsg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rapsg_pkg::CFG_DATA_W-1:0] i_cfg_data,

    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [rapsg_pkg::PRESSURE_W-1:0] i_pressure,
    input  logic [rapsg_pkg::TIME_W-1:0]     i_timestamp_us,
    input  logic                             i_conversion_ok,
    input  logic                             i_sample_ready,

    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_accepted,
    output logic [1:0]                       o_verdict,
    output logic                             o_step_confirmed,
    output logic [rapsg_pkg::PRESSURE_W-1:0] o_reference_pressure,
    output logic [rapsg_pkg::COUNT_W-1:0]    o_reject_total,
    output logic [rapsg_pkg::COUNT_W-1:0]    o_confirm_total,
    output logic [rapsg_pkg::COUNT_W-1:0]    o_invalid_total
);
    import rapsg_pkg::*;

    t_cfg    cfg;
    t_result judged;

    logic    r_in_valid;
    t_sample r_sample;
    logic    r_out_valid;
    t_result r_result;

    logic    fire;
    logic    in_load;

    // The judged word moves to the output register whenever that register is empty or
    // is being drained in this same cycle.
    assign fire    = r_in_valid && (!r_out_valid || !i_stall);

    // The input register is blocked only when it holds a word that cannot move on.
    assign o_stall = r_in_valid && !fire;
    assign in_load = i_valid && !o_stall;

    rapsg_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rapsg_judge u_judge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_sample (r_sample),
        .i_cfg    (cfg),
        .o_result (judged)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_sample.pressure      <= i_pressure;
            r_sample.timestamp_us  <= i_timestamp_us;
            r_sample.conversion_ok <= i_conversion_ok;
            r_sample.sample_ready  <= i_sample_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= judged;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_accepted           = r_result.accepted;
    assign o_verdict            = r_result.verdict;
    assign o_step_confirmed     = r_result.step_confirmed;
    assign o_reference_pressure = r_result.reference_pressure;
    assign o_reject_total       = r_result.reject_total;
    assign o_confirm_total      = r_result.confirm_total;
    assign o_invalid_total      = r_result.invalid_total;

endmodule

FILE: bench/rate_aware_pressure_step_guard_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the pressure step guard. Every input word that the block accepts is
// run through a local model of the guard, and the predicted result word is queued. A monitor
// pops one prediction for every result word that leaves the block and compares it field by
// field. Configuration is only changed while nothing is in flight.
module rate_aware_pressure_step_guard_test;

    import rapsg_pkg::*;

    localparam int          RESET_CYCLES    = 5;
    localparam int          DRAIN_SLACK     = 4;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int          MAX_REPORTS     = 40;
    localparam int          ITEMS_PER_PHASE = 580;
    localparam int          PRESSURE_MAX    = (1 << PRESSURE_W) - 1;

    // Index 7 has no register behind it, so a write there must leave everything unchanged.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    // Every input of the block starts at a known value.
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx       = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_valid         = 1'b0;
    logic [PRESSURE_W-1:0] i_pressure      = '0;
    logic [TIME_W-1:0]     i_timestamp_us  = '0;
    logic                  i_conversion_ok = 1'b0;
    logic                  i_sample_ready  = 1'b0;
    logic                  i_stall         = 1'b0;

    logic                  o_stall;
    logic                  o_valid;
    logic                  o_accepted;
    logic [1:0]            o_verdict;
    logic                  o_step_confirmed;
    logic [PRESSURE_W-1:0] o_reference_pressure;
    logic [COUNT_W-1:0]    o_reject_total;
    logic [COUNT_W-1:0]    o_confirm_total;
    logic [COUNT_W-1:0]    o_invalid_total;

    // Local copy of the configuration and of the guard state, kept in step with the block.
    t_cfg                  guard_cfg;
    logic                  anchor_valid;
    logic [PRESSURE_W-1:0] anchor_level;
    logic [TIME_W-1:0]     anchor_time;
    logic                  suspect_valid;
    logic [PRESSURE_W-1:0] suspect_level;
    logic [COUNT_W-1:0]    rejects_seen;
    logic [COUNT_W-1:0]    confirms_seen;
    logic [COUNT_W-1:0]    invalids_seen;

    // Predicted result words, oldest first.
    t_result               pending_verdicts[$];

    int unsigned           cycle_count    = 0;
    int                    mismatch_count = 0;
    int                    send_gap_pct   = 0;
    int                    recv_stall_pct = 0;
    logic [TIME_W-1:0]     sweep_us       = '0;

    always #6 i_clk = ~i_clk;

    rate_aware_pressure_step_guard i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_pressure           (i_pressure),
        .i_timestamp_us       (i_timestamp_us),
        .i_conversion_ok      (i_conversion_ok),
        .i_sample_ready       (i_sample_ready),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_accepted           (o_accepted),
        .o_verdict            (o_verdict),
        .o_step_confirmed     (o_step_confirmed),
        .o_reference_pressure (o_reference_pressure),
        .o_reject_total       (o_reject_total),
        .o_confirm_total      (o_confirm_total),
        .o_invalid_total      (o_invalid_total)
    );

    // A hung handshake or a lost result word ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("MISMATCH cycle %0d: %s got 0x%0h expected 0x%0h",
                     cycle_count, what, got, want);
        end
    endtask

    function automatic void reset_model();
        guard_cfg.min_pressure      = MIN_PRESSURE_RST;
        guard_cfg.max_pressure      = MAX_PRESSURE_RST;
        guard_cfg.hard_jump         = HARD_JUMP_RST;
        guard_cfg.base_jump         = BASE_JUMP_RST;
        guard_cfg.max_rate          = MAX_RATE_RST;
        guard_cfg.confirm_tolerance = CONFIRM_TOLERANCE_RST;
        guard_cfg.guard_enable      = 1'b1;
        anchor_valid  = 1'b0;
        anchor_level  = '0;
        anchor_time   = '0;
        suspect_valid = 1'b0;
        suspect_level = '0;
        rejects_seen  = '0;
        confirms_seen = '0;
        invalids_seen = '0;
    endfunction

    function automatic logic [PRESSURE_W-1:0] level_gap(input logic [PRESSURE_W-1:0] a,
                                                        input logic [PRESSURE_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Judges one sample against the guard state, updates that state and returns the word
    // that the block must produce for it.
    function automatic t_result judge_sample(input t_sample s);
        t_result               r;
        logic [PRESSURE_W-1:0] step;
        logic [TIME_W-1:0]     elapsed;
        logic [63:0]           allowance;
        r                = '0;
        r.verdict        = VERDICT_ACCEPT;
        r.step_confirmed = 1'b0;
        if (!s.conversion_ok || !s.sample_ready || s.pressure < guard_cfg.min_pressure ||
                s.pressure > guard_cfg.max_pressure) begin
            r.verdict     = VERDICT_INVALID;
            invalids_seen = invalids_seen + 1'b1;
        end else if (!guard_cfg.guard_enable || !anchor_valid) begin
            anchor_valid  = 1'b1;
            anchor_level  = s.pressure;
            anchor_time   = s.timestamp_us;
            suspect_valid = 1'b0;
        end else begin
            step = level_gap(s.pressure, anchor_level);
            if (step > guard_cfg.hard_jump) begin
                r.verdict = VERDICT_HARD_JUMP;
            end else begin
                // The elapsed time wraps, so a timestamp going backwards reads as a long wait.
                elapsed   = s.timestamp_us - anchor_time;
                allowance = 64'(guard_cfg.base_jump) +
                            ((64'(guard_cfg.max_rate) * 64'(elapsed)) >> RATE_SHIFT);
                if (allowance > 64'(guard_cfg.hard_jump)) begin
                    allowance = 64'(guard_cfg.hard_jump);
                end
                if (64'(step) <= allowance) begin
                    if (suspect_valid &&
                            level_gap(s.pressure, suspect_level) <=
                            guard_cfg.confirm_tolerance) begin
                        r.step_confirmed = 1'b1;
                        confirms_seen    = confirms_seen + 1'b1;
                    end
                    anchor_level  = s.pressure;
                    anchor_time   = s.timestamp_us;
                    suspect_valid = 1'b0;
                end else begin
                    r.verdict = VERDICT_RATE;
                end
            end
            // Either rejection makes the sample the pending candidate.
            if (r.verdict != VERDICT_ACCEPT) begin
                suspect_valid = 1'b1;
                suspect_level = s.pressure;
                rejects_seen  = rejects_seen + 1'b1;
            end
        end
        r.accepted           = (r.verdict == VERDICT_ACCEPT);
        r.reference_pressure = anchor_level;
        r.reject_total       = rejects_seen;
        r.confirm_total      = confirms_seen;
        r.invalid_total      = invalids_seen;
        return r;
    endfunction

    // Offers one word, holds it steady until the block takes it, then queues its prediction.
    // Valid is left high on return so that back-to-back words need no extra assignment.
    task automatic send_sample(input logic [PRESSURE_W-1:0] level,
                               input logic [TIME_W-1:0] stamp,
                               input logic conv_ok, input logic ready);
        t_sample s;
        s.pressure      = level;
        s.timestamp_us  = stamp;
        s.conversion_ok = conv_ok;
        s.sample_ready  = ready;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_pressure      <= level;
        i_timestamp_us  <= stamp;
        i_conversion_ok <= conv_ok;
        i_sample_ready  <= ready;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        pending_verdicts.push_back(judge_sample(s));
    endtask

    // Stops sending and waits until every predicted word has come back, plus a short margin.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    // Leaves the write enable high so that consecutive writes need no extra assignment.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_MIN_PRESSURE:      guard_cfg.min_pressure      = data;
            CFG_MAX_PRESSURE:      guard_cfg.max_pressure      = data;
            CFG_HARD_JUMP:         guard_cfg.hard_jump         = data;
            CFG_BASE_JUMP:         guard_cfg.base_jump         = data;
            CFG_MAX_RATE:          guard_cfg.max_rate          = data[RATE_W-1:0];
            CFG_CONFIRM_TOLERANCE: guard_cfg.confirm_tolerance = data;
            CFG_GUARD_ENABLE:      guard_cfg.guard_enable      = data[0];
            default: ;
        endcase
    endtask

    // Writes every register once. The narrow registers get random upper data bits, which the
    // block has to drop, and the unused index gets a random write as well.
    task automatic load_config(input t_cfg setting);
        wait_drained();
        put_reg(CFG_MIN_PRESSURE, setting.min_pressure);
        put_reg(CFG_MAX_PRESSURE, setting.max_pressure);
        put_reg(CFG_HARD_JUMP, setting.hard_jump);
        put_reg(CFG_BASE_JUMP, setting.base_jump);
        put_reg(CFG_MAX_RATE, {1'($urandom_range(0, 1)), setting.max_rate});
        put_reg(CFG_CONFIRM_TOLERANCE, setting.confirm_tolerance);
        put_reg(CFG_GUARD_ENABLE, {20'($urandom()), setting.guard_enable});
        put_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom()));
        i_cfg_we <= 1'b0;
    endtask

    // Monitor and receiver stall. The stall sampled here is the one the block saw at this
    // edge, since the new value only lands after the edge.
    always @(posedge i_clk) begin : result_check
        t_result seen;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            seen.accepted           = o_accepted;
            seen.verdict            = t_verdict'(o_verdict);
            seen.step_confirmed     = o_step_confirmed;
            seen.reference_pressure = o_reference_pressure;
            seen.reject_total       = o_reject_total;
            seen.confirm_total      = o_confirm_total;
            seen.invalid_total      = o_invalid_total;
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result word with nothing expected", 0, 0);
            end else begin
                want = pending_verdicts.pop_front();
                if (seen.accepted !== want.accepted)
                    report_mismatch("accepted", seen.accepted, want.accepted);
                if (seen.verdict !== want.verdict)
                    report_mismatch("verdict", seen.verdict, want.verdict);
                if (seen.step_confirmed !== want.step_confirmed)
                    report_mismatch("step_confirmed", seen.step_confirmed,
                                    want.step_confirmed);
                if (seen.reference_pressure !== want.reference_pressure)
                    report_mismatch("reference_pressure", seen.reference_pressure,
                                    want.reference_pressure);
                if (seen.reject_total !== want.reject_total)
                    report_mismatch("reject_total", seen.reject_total, want.reject_total);
                if (seen.confirm_total !== want.confirm_total)
                    report_mismatch("confirm_total", seen.confirm_total, want.confirm_total);
                if (seen.invalid_total !== want.invalid_total)
                    report_mismatch("invalid_total", seen.invalid_total, want.invalid_total);
            end
        end
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Runs on the reset values: first reference, small step, both rejections, a confirmed
    // step, every kind of invalid sample, the range edges, a backwards timestamp and a step
    // of exactly the hard limit against one just above it.
    task automatic test_reset_defaults_and_steps();
        send_sample(21'd1000000, 32'd0, 1'b1, 1'b1);
        send_sample(21'd1000500, 32'd10, 1'b1, 1'b1);
        send_sample(21'd1040000, 32'd20, 1'b1, 1'b1);
        send_sample(21'd1010000, 32'd30, 1'b1, 1'b1);
        // After a full rate period the allowance covers the step, and the sample sits within
        // tolerance of the rate-rejected candidate, so the step counts as confirmed.
        send_sample(21'd1010100, 32'd30 + (32'd1 << RATE_SHIFT), 1'b1, 1'b1);
        send_sample(21'd1010100, 32'd40, 1'b0, 1'b1);
        send_sample(21'd1010100, 32'd50, 1'b1, 1'b0);
        send_sample(21'd1010100, 32'd60, 1'b0, 1'b0);
        send_sample(21'd479999, 32'd70, 1'b1, 1'b1);
        send_sample(21'd1760001, 32'd80, 1'b1, 1'b1);
        send_sample(21'd0, 32'd90, 1'b1, 1'b1);
        send_sample(21'h1FFFFF, 32'd100, 1'b1, 1'b1);
        send_sample(21'd480000, 32'd110, 1'b1, 1'b1);
        send_sample(21'd1760000, 32'd120, 1'b1, 1'b1);
        send_sample(21'd1010200, 32'd0, 1'b1, 1'b1);
        send_sample(21'd1042200, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_sample(21'd1010199, 32'h7FFF_FFFF, 1'b1, 1'b1);
    endtask

    // With the guard off every valid word moves the reference, however far it jumps.
    task automatic test_guard_disabled();
        t_cfg setting;
        setting              = guard_cfg;
        setting.guard_enable = 1'b0;
        load_config(setting);
        send_sample(21'd100000, 32'd5, 1'b1, 1'b1);
        send_sample(21'd500000, 32'd6, 1'b1, 1'b1);
        send_sample(21'd1700000, 32'd7, 1'b1, 1'b1);
    endtask

    // A minimum above the maximum leaves no valid pressure at all.
    task automatic test_crossed_range();
        t_cfg setting;
        setting              = guard_cfg;
        setting.guard_enable = 1'b1;
        setting.min_pressure = 21'd1500000;
        setting.max_pressure = 21'd1000000;
        load_config(setting);
        send_sample(21'd1200000, 32'd8, 1'b1, 1'b1);
        send_sample(21'd1500000, 32'd9, 1'b1, 1'b1);
    endtask

    task automatic test_register_extremes();
        t_cfg setting;
        // Every limit at zero over the full range: only an unchanged level gets through.
        setting.min_pressure      = '0;
        setting.max_pressure      = 21'h1FFFFF;
        setting.hard_jump         = '0;
        setting.base_jump         = '0;
        setting.max_rate          = '0;
        setting.confirm_tolerance = '0;
        setting.guard_enable      = 1'b1;
        load_config(setting);
        send_sample(21'd0, 32'd0, 1'b1, 1'b1);
        send_sample(anchor_level, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_sample(21'h1FFFFF, 32'd1, 1'b1, 1'b1);
        // Every limit at its top: any step is allowed.
        setting.hard_jump         = 21'h1FFFFF;
        setting.base_jump         = 21'h1FFFFF;
        setting.max_rate          = 20'hFFFFF;
        setting.confirm_tolerance = 21'h1FFFFF;
        load_config(setting);
        send_sample(21'd0, 32'd2, 1'b1, 1'b1);
        send_sample(21'h1FFFFF, 32'd3, 1'b1, 1'b1);
        // A range of a single value.
        setting                   = guard_cfg;
        setting.min_pressure      = 21'd700000;
        setting.max_pressure      = 21'd700000;
        load_config(setting);
        send_sample(21'd700000, 32'd4, 1'b1, 1'b1);
        send_sample(21'd700001, 32'd5, 1'b1, 1'b1);
    endtask

    function automatic t_cfg random_config();
        t_cfg c;
        c.min_pressure = PRESSURE_W'($urandom_range(0, 600000));
        c.max_pressure = PRESSURE_W'($urandom_range(1400000, PRESSURE_MAX));
        c.hard_jump    = PRESSURE_W'($urandom_range(500, 80000));
        c.base_jump    = PRESSURE_W'($urandom_range(0, c.hard_jump));
        if ($urandom_range(0, 4) != 0) begin
            c.max_rate = RATE_W'($urandom_range(0, 200000));
        end else begin
            c.max_rate = RATE_W'($urandom());
        end
        c.confirm_tolerance = PRESSURE_W'($urandom_range(0, 4000));
        c.guard_enable      = ($urandom_range(0, 9) != 0);
        return c;
    endfunction

    // Most words walk near the current reference or back toward the pending candidate, with
    // steps scaled to the allowance and hard limit, so rejections and confirmations happen
    // often. The rest are flags low, arbitrary pressures and arbitrary timestamps.
    task automatic send_random_sample();
        int unsigned roll;
        int          lvl;
        int          span;
        int          offset;
        logic        conv_ok;
        logic        ready;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            sweep_us = sweep_us + $urandom_range(0, 4095);
        end else if (roll < 90) begin
            sweep_us = sweep_us + $urandom_range(0, 1 << 22);
        end else if (roll < 95) begin
            sweep_us = sweep_us - $urandom_range(0, 1 << 20);
        end else begin
            sweep_us = $urandom();
        end
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            lvl = $urandom_range(0, PRESSURE_MAX);
        end else begin
            if (anchor_valid) begin
                lvl = int'(anchor_level);
            end else begin
                lvl = (int'(guard_cfg.min_pressure) + int'(guard_cfg.max_pressure)) / 2;
            end
            if (suspect_valid && roll < 35) begin
                lvl  = int'(suspect_level);
                span = int'(guard_cfg.confirm_tolerance) + 4;
            end else if (roll < 60) begin
                span = int'(guard_cfg.base_jump) + 8;
            end else if (roll < 85) begin
                span = int'(guard_cfg.hard_jump) + 8;
            end else begin
                span = 2 * int'(guard_cfg.hard_jump) + 8;
            end
            offset = $urandom_range(0, span);
            lvl    = ($urandom_range(0, 1) != 0) ? lvl + offset : lvl - offset;
            if (lvl < 0) begin
                lvl = 0;
            end else if (lvl > PRESSURE_MAX) begin
                lvl = PRESSURE_MAX;
            end
        end
        if ($urandom_range(0, 99) < 8) begin
            {conv_ok, ready} = 2'($urandom_range(0, 2));
        end else begin
            {conv_ok, ready} = 2'b11;
        end
        send_sample(PRESSURE_W'(lvl), sweep_us, conv_ok, ready);
    endtask

    // One phase of random traffic under one idling pattern. Halfway through, the sender
    // holds off until every result word is back, and a fresh setting is loaded.
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        send_gap_pct   = send_pct;
        recv_stall_pct = recv_pct;
        load_config(random_config());
        repeat (ITEMS_PER_PHASE / 2) send_random_sample();
        load_config(random_config());
        repeat (ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2) send_random_sample();
    endtask

    initial begin
        reset_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_gap_pct   = 14;
        recv_stall_pct = 76;
        test_reset_defaults_and_steps();
        test_guard_disabled();
        test_crossed_range();
        test_register_extremes();
        test_random_traffic(14, 76);
        test_random_traffic(76, 14);
        test_random_traffic(0, 0);
        wait_drained();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
